// File: src/ltfc_pkg.sv
// Shared types, constants and helpers for the link token flow control block.
// Used by ltfc_queue, ltfc_engine and link_token_flow_control; no dependencies.
package ltfc_pkg;

	// Default sizing, handed down through the top-level parameters.
	localparam int TX_DEPTH_DEF   = 16;
	localparam int RX_DEPTH_DEF   = 16;
	localparam int TOKEN_BITS_DEF = 10;

	// Field widths fixed by the packet format.
	localparam int FLIT_W  = 5;
	localparam int TAG_W   = 8;
	localparam int RTC_W   = 10;
	localparam int BUSY_W  = 12;
	localparam int CFG_W   = 16;
	localparam int CADDR_W = 2;

	// Configuration register indexes.
	localparam logic [CADDR_W-1:0] CFG_INIT_TOKENS = 2'd0;
	localparam logic [CADDR_W-1:0] CFG_HOST_SOURCE = 2'd1;
	localparam logic [CADDR_W-1:0] CFG_FLIT_TIME   = 2'd2;

	// Flit time after reset: 1.0 in 8.8 fixed point.
	localparam logic [CFG_W-1:0] FLIT_TIME_RST = 16'd256;

	typedef enum logic [1:0] {
		REQ_ENQUEUE = 2'd0,
		REQ_SEND    = 2'd1,
		REQ_RECEIVE = 2'd2,
		REQ_EXTRACT = 2'd3
	} req_e_t;

	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_TOKEN   = 3'd1,
		KIND_NULL    = 3'd2,
		KIND_ACCEPT  = 3'd3,
		KIND_REJECT  = 3'd4,
		KIND_EXTRACT = 3'd5
	} kind_e_t;

	// One queue entry: flit count and tag.
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [FLIT_W-1:0] flits;
	} entry_t;

	// One input transaction.
	typedef struct packed {
		req_e_t            req;
		logic [FLIT_W-1:0] flits;
		logic [TAG_W-1:0]  tag;
		logic              is_flow;
		logic [RTC_W-1:0]  rtc;
	} item_t;

	// One result transaction.
	typedef struct packed {
		kind_e_t           kind;
		logic [FLIT_W-1:0] sent_flits;
		logic [RTC_W-1:0]  sent_rtc;
		logic [TAG_W-1:0]  sent_tag;
		logic [BUSY_W-1:0] busy_cycles;
		logic              head_valid;
		logic [RTC_W-1:0]  tokens_now;
	} result_t;

	// Queue controls from the engine.
	typedef struct packed {
		logic tx_push;
		logic tx_pop;
		logic rx_push;
		logic rx_pop;
	} q_ctl_t;

	// Queue status toward the engine.
	typedef struct packed {
		logic tx_empty;
		logic tx_full;
		logic rx_empty;
		logic rx_full;
	} q_stat_t;

	// Highest power of two not above v (zero for zero).
	function automatic logic [RTC_W-1:0] top_pow(input logic [RTC_W-1:0] v);
		logic [RTC_W-1:0] p;
		p = '0;
		for (int i = 0; i < RTC_W; i++) begin
			if (v[i]) begin
				p = RTC_W'(1) << i;
			end
		end
		return p;
	endfunction

endpackage

// File: src/link_token_flow_control.sv
// Link token flow control: one end of a credit-based serial link.
// Path from input transaction to result: input register, then result register.
// Throughput: one transaction per cycle while the result side is ready; both queues and counters update in one pass.
// Reset: queues empty, tokens held and freed zero, host mode off, flit time 256.
// Depends on ltfc_pkg, ltfc_queue and ltfc_engine.
module link_token_flow_control #(
	parameter int TX_DEPTH   = ltfc_pkg::TX_DEPTH_DEF,
	parameter int RX_DEPTH   = ltfc_pkg::RX_DEPTH_DEF,
	parameter int TOKEN_BITS = ltfc_pkg::TOKEN_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ltfc_pkg::CADDR_W-1:0]  cfg_addr,
	input  logic [ltfc_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,  // pkt_flits, pkt_tag, pkt_rtc, pad
	input  logic [2:0]                    s_axis_tuser,  // req_type, pkt_is_flow
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [47:0]                   m_axis_tdata,  // sent_flits, sent_rtc, sent_tag,
	                                                     // busy_cycles, tokens_now, pad
	output logic [3:0]                    m_axis_tuser   // result_kind, head_valid
);
	import ltfc_pkg::*;

	logic     valid_s1;
	item_t    item_s1;
	logic     res_valid_q;
	result_t  res_q;
	logic     fire;
	q_ctl_t   ctl;
	q_stat_t  stat;
	result_t  res;
	entry_t   tx_head;
	entry_t   rx_head;
	entry_t   push_entry;

	// The stage fires when the result register is free or being drained.
	assign fire          = valid_s1 && (!res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;
	assign push_entry    = '{tag: item_s1.tag, flits: item_s1.flits};

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.req     <= req_e_t'(s_axis_tuser[1:0]);
			item_s1.is_flow <= s_axis_tuser[2];
			item_s1.flits   <= s_axis_tdata[4:0];
			item_s1.tag     <= s_axis_tdata[12:5];
			item_s1.rtc     <= s_axis_tdata[22:13];
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.tokens_now, res_q.busy_cycles, res_q.sent_tag,
		res_q.sent_rtc, res_q.sent_flits};
	assign m_axis_tuser  = {res_q.head_valid, res_q.kind};

	ltfc_queue #(
		.DEPTH(TX_DEPTH)
	) u_tx_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ctl.tx_push),
		.push_data(push_entry),
		.pop      (ctl.tx_pop),
		.head     (tx_head),
		.empty    (stat.tx_empty),
		.full     (stat.tx_full)
	);

	ltfc_queue #(
		.DEPTH(RX_DEPTH)
	) u_rx_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ctl.rx_push),
		.push_data(push_entry),
		.pop      (ctl.rx_pop),
		.head     (rx_head),
		.empty    (stat.rx_empty),
		.full     (stat.rx_full)
	);

	ltfc_engine #(
		.TOKEN_BITS(TOKEN_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.fire     (fire),
		.item     (item_s1),
		.tx_head  (tx_head),
		.rx_head  (rx_head),
		.stat     (stat),
		.ctl      (ctl),
		.res      (res)
	);

endmodule

// File: src/ltfc_queue.sv
// Packet queue with a registered head entry, used for both link directions.
// Depends on ltfc_pkg for the entry type.
module ltfc_queue #(
	parameter int DEPTH = ltfc_pkg::TX_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ltfc_pkg::entry_t  push_data,
	input  logic              pop,
	output ltfc_pkg::entry_t  head,
	output logic              empty,
	output logic              full
);
	import ltfc_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem [DEPTH];
	entry_t          head_q;
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW-1:0]   rd_next;
	logic [PW-1:0]   wr_next;
	logic [CW-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign head  = head_q;

	// Pointer advance with wrap at the depth.
	always_comb begin
		rd_next = rd_ptr_q;
		wr_next = wr_ptr_q;
		if (pop) begin
			rd_next = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
		end
		if (push) begin
			wr_next = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_next;
			rd_ptr_q <= rd_next;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage write and registered head read; a write into the slot that
	// becomes the head is forwarded straight to the head register.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (push && (wr_ptr_q == rd_next)) begin
			head_q <= push_data;
		end else begin
			head_q <= mem[rd_next];
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from an empty queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fill count did not follow a push");

endmodule

// File: src/ltfc_engine.sv
// Per-transaction decision logic, configuration and token counters.
// Depends on ltfc_pkg; drives the queue controls and forms one result.
module ltfc_engine #(
	parameter int TOKEN_BITS = ltfc_pkg::TOKEN_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ltfc_pkg::CADDR_W-1:0]  cfg_addr,
	input  logic [ltfc_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          fire,
	input  ltfc_pkg::item_t               item,
	input  ltfc_pkg::entry_t              tx_head,
	input  ltfc_pkg::entry_t              rx_head,
	input  ltfc_pkg::q_stat_t             stat,
	output ltfc_pkg::q_ctl_t              ctl,
	output ltfc_pkg::result_t             res
);
	import ltfc_pkg::*;

	// Working width that holds any token count and any 10-bit increment.
	localparam int XW = ((TOKEN_BITS > RTC_W) ? TOKEN_BITS : RTC_W) + 1;
	localparam logic [XW-1:0] TMAX    = XW'((64'd1 << TOKEN_BITS) - 64'd1);
	localparam logic [XW-1:0] RTC_MAX = XW'({RTC_W{1'b1}});

	logic                  host_q;
	logic [CFG_W-1:0]      flit_time_q;
	logic [TOKEN_BITS-1:0] held_q;
	logic [TOKEN_BITS-1:0] freed_q;
	logic [TOKEN_BITS-1:0] held_d;
	logic [TOKEN_BITS-1:0] freed_d;
	logic [XW-1:0]         init_clamp;
	logic [XW-1:0]         held_sum;
	logic [XW-1:0]         freed_sum;
	logic [RTC_W-1:0]      freed_clamp;
	logic [RTC_W-1:0]      rtc;
	logic                  can_send;
	logic [FLIT_W-1:0]     mul_flits;
	logic [20:0]           prod;
	logic [21:0]           prod_rnd;
	logic [BUSY_W-1:0]     busy;

	// Return count: largest power of two not above the freed tokens, clamped to the field range.
	assign freed_clamp = (XW'(freed_q) > RTC_MAX) ? {RTC_W{1'b1}} : RTC_W'(freed_q);
	assign rtc         = top_pow(freed_clamp);
	assign can_send    = !stat.tx_empty && (XW'(held_q) >= XW'(tx_head.flits));

	// Busy time: ceil(flits * flit_time / 256), saturated.
	assign mul_flits = (item.req == REQ_SEND && can_send) ? tx_head.flits : FLIT_W'(1);
	assign prod      = 21'(mul_flits) * 21'(flit_time_q);
	assign prod_rnd  = 22'(prod) + 22'd255;
	assign busy      = (prod_rnd[21:8] > 14'd4095) ? {BUSY_W{1'b1}} : prod_rnd[19:8];

	// Saturating adds and the clamped load value.
	assign held_sum   = XW'(held_q) + XW'(item.rtc);
	assign freed_sum  = XW'(freed_q) + XW'(rx_head.flits);
	assign init_clamp = (XW'(cfg_wdata[RTC_W-1:0]) > TMAX) ? TMAX
		: XW'(cfg_wdata[RTC_W-1:0]);

	// Decision for one transaction.
	always_comb begin
		ctl      = '0;
		res      = '0;
		res.kind = KIND_ACCEPT;
		held_d   = held_q;
		freed_d  = freed_q;
		unique case (item.req)
			REQ_ENQUEUE: begin
				if (stat.tx_full) begin
					res.kind = KIND_REJECT;
				end else begin
					ctl.tx_push = 1'b1;
				end
			end
			REQ_SEND: begin
				res.sent_flits  = FLIT_W'(1);
				res.busy_cycles = busy;
				if (can_send) begin
					ctl.tx_pop     = 1'b1;
					res.kind       = KIND_DATA;
					res.sent_flits = tx_head.flits;
					res.sent_tag   = tx_head.tag;
					res.sent_rtc   = rtc;
					freed_d        = freed_q - TOKEN_BITS'(rtc);
					if (!host_q) begin
						held_d = held_q - TOKEN_BITS'(tx_head.flits);
					end
				end else if (freed_q != '0) begin
					res.kind     = KIND_TOKEN;
					res.sent_rtc = rtc;
					freed_d      = freed_q - TOKEN_BITS'(rtc);
				end else begin
					res.kind = KIND_NULL;
				end
			end
			REQ_RECEIVE: begin
				held_d = (held_sum > TMAX) ? TOKEN_BITS'(TMAX) : TOKEN_BITS'(held_sum);
				if (!item.is_flow) begin
					if (stat.rx_full) begin
						res.kind = KIND_REJECT;
					end else begin
						ctl.rx_push = 1'b1;
					end
				end
			end
			REQ_EXTRACT: begin
				res.kind = KIND_EXTRACT;
				if (!stat.rx_empty) begin
					ctl.rx_pop     = 1'b1;
					res.sent_flits = rx_head.flits;
					res.sent_tag   = rx_head.tag;
					res.head_valid = 1'b1;
					freed_d = (freed_sum > TMAX) ? TOKEN_BITS'(TMAX)
						: TOKEN_BITS'(freed_sum);
				end
			end
			default: begin
				res.kind = KIND_ACCEPT;
			end
		endcase
		res.tokens_now = (XW'(held_d) > RTC_MAX) ? {RTC_W{1'b1}} : RTC_W'(held_d);
		if (!fire) begin
			ctl = '0;
		end
	end

	// Configuration registers and token counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_q      <= 1'b0;
			flit_time_q <= FLIT_TIME_RST;
			held_q      <= '0;
			freed_q     <= '0;
		end else begin
			if (fire) begin
				held_q  <= held_d;
				freed_q <= freed_d;
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_INIT_TOKENS: held_q      <= TOKEN_BITS'(init_clamp);
					CFG_HOST_SOURCE: host_q      <= cfg_wdata[0];
					CFG_FLIT_TIME:   flit_time_q <= cfg_wdata;
					default:         host_q      <= host_q;
				endcase
			end
		end
	end

	a_rtc_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> $onehot0(res.sent_rtc)) else $error("return count not a power of two");

	a_token_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.kind == KIND_TOKEN) |-> (res.sent_rtc != '0))
		else $error("token-return packet with empty return count");

	a_spend: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !cfg_we && !host_q && res.kind == KIND_DATA)
		|=> (held_q == $past(held_q) - $past(TOKEN_BITS'(tx_head.flits))))
		else $error("data send did not spend its tokens");

	a_freed_send: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.req == REQ_SEND) |=> (freed_q <= $past(freed_q)))
		else $error("freed count grew on a send slot");

endmodule

// File: sim/tb_link_token_flow_control.sv
// Testbench for link_token_flow_control: drives request transactions and checks every
// result against a cycle-free model of the token flow control kept inside the bench.
// Depends on ltfc_pkg and the RTL of link_token_flow_control.
module tb_link_token_flow_control;
	timeunit 1ns;
	timeprecision 1ps;

	import ltfc_pkg::*;

	localparam int TX_SLOTS  = 16;
	localparam int RX_SLOTS  = 16;
	localparam int TOKEN_TOP = 1023;
	localparam int BUSY_TOP  = 4095;
	localparam int STALL_LIMIT = 3000;

	// Clock, reset and block inputs, all known from time zero.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [CADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;

	// Model state of the link end.
	entry_t  tx_pending[$];
	entry_t  rx_pending[$];
	int      tokens_held;
	int      tokens_freed;
	bit      host_mode;
	int      flit_time_q;
	result_t expected_results[$];

	int err_count = 0;
	int result_count = 0;
	int stall_left = 0;
	int hold_request = 0;
	bit steady = 1'b0;
	int quiet_cycles = 0;

	link_token_flow_control u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle length for either side: none while steady is set, else mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady) begin
			return 0;
		end
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic int ceil_busy(int flits);
		longint c;
		c = (longint'(flits) * flit_time_q + 255) >>> 8;
		return (c > BUSY_TOP) ? BUSY_TOP : int'(c);
	endfunction

	function automatic int sat_tokens(int v);
		return (v > TOKEN_TOP) ? TOKEN_TOP : v;
	endfunction

	// Return count: largest power of two not above the freed count, taken off the freed count.
	function automatic int take_return_count();
		int p;
		int v;
		p = 0;
		v = (tokens_freed > TOKEN_TOP) ? TOKEN_TOP : tokens_freed;
		for (int b = 1; b <= v && b <= 512; b = b << 1) begin
			p = b;
		end
		tokens_freed -= p;
		return p;
	endfunction

	// Apply one request to the model and return the result it should produce.
	function automatic result_t link_predict(item_t it);
		result_t r;
		entry_t  e;
		r = '0;
		r.kind = KIND_ACCEPT;
		case (it.req)
			REQ_ENQUEUE: begin
				if (tx_pending.size() >= TX_SLOTS) begin
					r.kind = KIND_REJECT;
				end else begin
					e.flits = it.flits;
					e.tag = it.tag;
					tx_pending.insert(tx_pending.size(), e);
				end
			end
			REQ_SEND: begin
				if (tx_pending.size() > 0 && tokens_held >= int'(tx_pending[0].flits)) begin
					e = tx_pending[0];
					tx_pending.delete(0);
					r.sent_rtc = RTC_W'(take_return_count());
					if (!host_mode) begin
						tokens_held -= int'(e.flits);
					end
					r.kind = KIND_DATA;
					r.sent_flits = e.flits;
					r.sent_tag = e.tag;
					r.busy_cycles = BUSY_W'(ceil_busy(int'(e.flits)));
				end else if (tokens_freed > 0) begin
					r.sent_rtc = RTC_W'(take_return_count());
					r.kind = KIND_TOKEN;
					r.sent_flits = FLIT_W'(1);
					r.busy_cycles = BUSY_W'(ceil_busy(1));
				end else begin
					r.kind = KIND_NULL;
					r.sent_flits = FLIT_W'(1);
					r.busy_cycles = BUSY_W'(ceil_busy(1));
				end
			end
			REQ_RECEIVE: begin
				tokens_held = sat_tokens(tokens_held + int'(it.rtc));
				if (!it.is_flow) begin
					if (rx_pending.size() >= RX_SLOTS) begin
						r.kind = KIND_REJECT;
					end else begin
						e.flits = it.flits;
						e.tag = it.tag;
						rx_pending.insert(rx_pending.size(), e);
					end
				end
			end
			default: begin
				r.kind = KIND_EXTRACT;
				if (rx_pending.size() > 0) begin
					e = rx_pending[0];
					rx_pending.delete(0);
					tokens_freed = sat_tokens(tokens_freed + int'(e.flits));
					r.sent_flits = e.flits;
					r.sent_tag = e.tag;
					r.head_valid = 1'b1;
				end
			end
		endcase
		r.tokens_now = RTC_W'(sat_tokens(tokens_held));
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH: %s", msg);
		err_count++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want) begin
			report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				result_count, name, got, want));
		end
	endtask

	// Send one request transaction and record its expected result on acceptance.
	task automatic send_item(item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, it.rtc, it.tag, it.flits};
		s_axis_tuser <= {it.is_flow, it.req};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_results.insert(expected_results.size(), link_predict(it));
	endtask

	task automatic send_fields(req_e_t req, int flits, int tag, bit is_flow, int rtc);
		item_t it;
		it.req = req;
		it.flits = FLIT_W'(flits);
		it.tag = TAG_W'(tag);
		it.is_flow = is_flow;
		it.rtc = RTC_W'(rtc);
		send_item(it);
	endtask

	// Stop offering and wait until every expected result has come out.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the write port is deasserted again before the task returns.
	task automatic write_reg(logic [CADDR_W-1:0] addr, int value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			CFG_INIT_TOKENS: tokens_held = value & TOKEN_TOP;
			CFG_HOST_SOURCE: host_mode = value[0];
			CFG_FLIT_TIME:   flit_time_q = value & 16'hFFFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(int init_tokens, bit host, int ftime);
		wait_drained();
		write_reg(CFG_INIT_TOKENS, init_tokens);
		write_reg(CFG_HOST_SOURCE, host);
		write_reg(CFG_FLIT_TIME, ftime);
	endtask

	function automatic int rand_flits();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) begin
			return $urandom_range(1, 17);
		end else if (r < 94) begin
			return 0;
		end
		return $urandom_range(18, 31);
	endfunction

	// Random request; weights are percentages, extract takes what is left.
	function automatic item_t rand_item(int p_enq, int p_send, int p_recv);
		item_t it;
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (r < p_enq) begin
			it.req = REQ_ENQUEUE;
		end else if (r < p_enq + p_send) begin
			it.req = REQ_SEND;
		end else if (r < p_enq + p_send + p_recv) begin
			it.req = REQ_RECEIVE;
		end else begin
			it.req = REQ_EXTRACT;
		end
		it.flits = FLIT_W'(rand_flits());
		it.tag = TAG_W'($urandom_range(0, 255));
		it.is_flow = ($urandom_range(0, 99) < 30);
		k = $urandom_range(0, 99);
		if (it.req != REQ_RECEIVE || k >= 90) begin
			it.rtc = RTC_W'($urandom_range(0, 1023));
		end else if (k < 70) begin
			it.rtc = RTC_W'($urandom_range(0, 8));
		end else begin
			it.rtc = RTC_W'($urandom_range(0, 64));
		end
		return it;
	endfunction

	task automatic run_random(int count, int p_enq, int p_send, int p_recv);
		for (int i = 0; i < count; i++) begin
			send_item(rand_item(p_enq, p_send, p_recv));
		end
	endtask

	// Reset state, empty queues, saturation, zero-flit packets and return counts.
	task automatic test_reset_and_basics();
		send_fields(REQ_SEND, 0, 0, 0, 0);
		send_fields(REQ_EXTRACT, 0, 0, 0, 0);
		send_fields(REQ_ENQUEUE, 1, 8'h00, 0, 0);
		send_fields(REQ_SEND, 0, 0, 0, 0);
		send_fields(REQ_RECEIVE, 5, 8'h11, 1, 1023);
		send_fields(REQ_RECEIVE, 5, 8'h22, 1, 1);
		send_fields(REQ_SEND, 31, 8'hFF, 1, 1023);
		send_fields(REQ_RECEIVE, 31, 8'hFF, 0, 0);
		send_fields(REQ_EXTRACT, 0, 0, 0, 0);
		send_fields(REQ_SEND, 0, 0, 0, 0);
		send_fields(REQ_ENQUEUE, 0, 8'h5A, 1, 1023);
		send_fields(REQ_SEND, 0, 0, 0, 0);
		send_fields(REQ_ENQUEUE, 31, 8'hA5, 0, 0);
		send_fields(REQ_SEND, 0, 0, 0, 0);
		send_fields(REQ_RECEIVE, 17, 8'h3C, 0, 0);
		send_fields(REQ_RECEIVE, 5, 8'hC3, 1, 0);
		send_fields(REQ_EXTRACT, 0, 0, 0, 0);
		send_fields(REQ_EXTRACT, 0, 0, 0, 0);
		send_fields(REQ_SEND, 0, 0, 0, 0);
		send_fields(REQ_SEND, 0, 0, 0, 0);
		send_fields(REQ_SEND, 0, 0, 0, 0);
	endtask

	// Zero, largest and smallest nonzero flit time, including the busy count ceiling.
	task automatic test_flit_time_extremes();
		configure(1023, 0, 0);
		send_fields(REQ_SEND, 0, 0, 0, 0);
		configure(1023, 0, 65535);
		send_fields(REQ_ENQUEUE, 31, 8'h81, 0, 0);
		send_fields(REQ_SEND, 0, 0, 0, 0);
		configure(1023, 1, 1);
		send_fields(REQ_ENQUEUE, 17, 8'h42, 0, 0);
		send_fields(REQ_SEND, 0, 0, 0, 0);
		send_fields(REQ_SEND, 0, 0, 0, 0);
	endtask

	// Random traffic under several register settings.
	task automatic test_config_sweep();
		configure(0, 0, 256);
		run_random(140, 25, 30, 25);
		configure(1023, 1, 65535);
		run_random(140, 30, 30, 20);
		configure(17, 0, 1);
		steady = 1'b1;
		run_random(140, 25, 25, 30);
		steady = 1'b0;
		configure(500, 1, 384);
		run_random(140, 25, 30, 25);
		configure(1023, 0, 0);
		run_random(140, 30, 30, 20);
		configure(64, 0, 300);
		run_random(140, 25, 35, 20);
	endtask

	// Heavy enqueue fills the transmit queue; heavy receive fills the receive queue.
	task automatic test_queue_full();
		configure(0, 0, 256);
		run_random(50, 75, 10, 10);
		run_random(50, 5, 10, 80);
	endtask

	// Freed count is driven into saturation, then returned in power-of-two steps.
	task automatic test_freed_saturation();
		wait_drained();
		for (int i = 0; i < 40; i++) begin
			send_fields(REQ_RECEIVE, 31, $urandom_range(0, 255), 0, 0);
			send_fields(REQ_EXTRACT, 0, 0, 0, 0);
		end
		for (int i = 0; i < 14; i++) begin
			send_fields(REQ_SEND, 0, 0, 0, 0);
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_backpressure();
		wait_drained();
		hold_request = 250;
		steady = 1'b1;
		run_random(80, 25, 30, 25);
		steady = 1'b0;
	endtask

	// Result side: ready with random stalls, and a long hold when requested.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_count++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					result_count));
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				check_field("result_kind", m_axis_tuser[2:0], want.kind);
				check_field("sent_flits", m_axis_tdata[4:0], want.sent_flits);
				check_field("sent_rtc", m_axis_tdata[14:5], want.sent_rtc);
				check_field("sent_tag", m_axis_tdata[22:15], want.sent_tag);
				check_field("busy_cycles", m_axis_tdata[34:23], want.busy_cycles);
				check_field("head_valid", m_axis_tuser[3], want.head_valid);
				check_field("tokens_now", m_axis_tdata[44:35], want.tokens_now);
			end
		end
	end

	// Watchdog: cycles with work pending but no transaction on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(expected_results.size() == 0 && !s_axis_tvalid)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TIMEOUT: no transaction for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		tokens_held = 0;
		tokens_freed = 0;
		host_mode = 1'b0;
		flit_time_q = FLIT_TIME_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_basics();
		test_flit_time_extremes();
		test_config_sweep();
		test_queue_full();
		test_freed_saturation();
		test_backpressure();

		wait_drained();
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		end
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
